// File: src/fracred_pkg.sv
// ============================================================================
// fracred_pkg: shared types and microprogram of the fraction reducer
// Holds the micro-operation and jump-condition codes, the control word
// layout, the status flags the datapath reports, and the control store.
// ============================================================================
package fracred_pkg;

    // Micro-operations carried out by the datapath
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_SUB,
        OP_DIV_INIT_N,
        OP_DIV_INIT_D,
        OP_DIV_STEP,
        OP_ZERO_NUM,
        OP_EMIT,
        OP_EMIT_ERR
    } uop_t;

    // Jump conditions; a taken jump suppresses the step's operation
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_B_ZERO,
        COND_A_ZERO,
        COND_NOT_BOTH_EVEN,
        COND_A_ODD,
        COND_B_ODD,
        COND_DIV_DONE,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [3:0] upc_t;

    // One control word: operation, condition, target when taken, target otherwise
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  jump;
        upc_t  next;
    } ucode_t;

    // Status the datapath reports to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic b_odd;
        logic div_done;
    } flags_t;

    // Sequencer outputs to the datapath
    typedef struct packed {
        uop_t op;
        logic idle;
    } seq_out_t;

    // Step addresses
    localparam upc_t PC_IDLE      = 4'd0;
    localparam upc_t PC_CHK_D     = 4'd1;
    localparam upc_t PC_CHK_N     = 4'd2;
    localparam upc_t PC_COMMON2   = 4'd3;
    localparam upc_t PC_ODD_A     = 4'd4;
    localparam upc_t PC_SUB       = 4'd5;
    localparam upc_t PC_SUB_CHK   = 4'd6;
    localparam upc_t PC_ODD_B     = 4'd7;
    localparam upc_t PC_DIV_N     = 4'd8;
    localparam upc_t PC_DIV_N_RUN = 4'd9;
    localparam upc_t PC_DIV_D     = 4'd10;
    localparam upc_t PC_DIV_D_RUN = 4'd11;
    localparam upc_t PC_EMIT      = 4'd12;
    localparam upc_t PC_ERR       = 4'd13;
    localparam upc_t PC_ZERO_NUM  = 4'd14;

    // Control store: zero checks, binary gcd on the magnitudes, then two restoring divisions and the output step
    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:      w = '{OP_LOAD,       COND_NO_INPUT,      PC_IDLE,      PC_CHK_D};
            PC_CHK_D:     w = '{OP_NOP,        COND_B_ZERO,        PC_ERR,       PC_CHK_N};
            PC_CHK_N:     w = '{OP_NOP,        COND_A_ZERO,        PC_ZERO_NUM,  PC_COMMON2};
            PC_COMMON2:   w = '{OP_HALVE_BOTH, COND_NOT_BOTH_EVEN, PC_ODD_A,     PC_COMMON2};
            PC_ODD_A:     w = '{OP_HALVE_A,    COND_A_ODD,         PC_ODD_B,     PC_ODD_A};
            PC_SUB:       w = '{OP_SUB,        COND_NEVER,         PC_SUB,       PC_SUB_CHK};
            PC_SUB_CHK:   w = '{OP_HALVE_B,    COND_B_ZERO,        PC_DIV_N,     PC_ODD_B};
            PC_ODD_B:     w = '{OP_HALVE_B,    COND_B_ODD,         PC_SUB,       PC_ODD_B};
            PC_DIV_N:     w = '{OP_DIV_INIT_N, COND_NEVER,         PC_DIV_N,     PC_DIV_N_RUN};
            PC_DIV_N_RUN: w = '{OP_DIV_STEP,   COND_DIV_DONE,      PC_DIV_D,     PC_DIV_N_RUN};
            PC_DIV_D:     w = '{OP_DIV_INIT_D, COND_NEVER,         PC_DIV_D,     PC_DIV_D_RUN};
            PC_DIV_D_RUN: w = '{OP_DIV_STEP,   COND_DIV_DONE,      PC_EMIT,      PC_DIV_D_RUN};
            PC_EMIT:      w = '{OP_EMIT,       COND_OUT_BUSY,      PC_EMIT,      PC_IDLE};
            PC_ERR:       w = '{OP_EMIT_ERR,   COND_OUT_BUSY,      PC_ERR,       PC_IDLE};
            PC_ZERO_NUM:  w = '{OP_ZERO_NUM,   COND_NEVER,         PC_ZERO_NUM,  PC_EMIT};
            default:      w = '{OP_NOP,        COND_NEVER,         PC_IDLE,      PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: src/fracred_seq.sv
// ============================================================================
// fracred_seq: microprogram sequencer of the fraction reducer
// Fetches one control word per cycle, tests its jump condition against the
// datapath flags and either issues the operation or takes the jump.
// ============================================================================
module fracred_seq
    import fracred_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  flags_t   flags,
    output seq_out_t ctl
);

    upc_t   pc_reg;
    upc_t   pc_next;
    ucode_t word;
    logic   hit;

    // Condition test on the current control word
    always_comb begin
        word = ucode_rom(pc_reg);
        unique case (word.cond)
            COND_NEVER:         hit = 1'b0;
            COND_NO_INPUT:      hit = !flags.in_valid;
            COND_B_ZERO:        hit = flags.b_zero;
            COND_A_ZERO:        hit = flags.a_zero;
            COND_NOT_BOTH_EVEN: hit = flags.a_odd || flags.b_odd;
            COND_A_ODD:         hit = flags.a_odd;
            COND_B_ODD:         hit = flags.b_odd;
            COND_DIV_DONE:      hit = flags.div_done;
            COND_OUT_BUSY:      hit = flags.out_busy;
            default:            hit = 1'b0;
        endcase
    end

    // A taken jump suppresses the operation of the step
    always_comb begin
        ctl.op   = hit ? OP_NOP : word.op;
        ctl.idle = (pc_reg == PC_IDLE);
        pc_next  = hit ? word.jump : word.next;
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: src/fraction_reducer.sv
// ============================================================================
// fraction_reducer: reduces a signed fraction to lowest terms
// Finds the gcd of the operand magnitudes with a binary gcd loop, divides
// both by it with a shared restoring divider and puts the sign on the
// numerator. A zero denominator returns zero words with the error flag.
// ============================================================================
// Operation: the checks, then the gcd steps (one halving, subtraction or test per
// cycle), the two divisions and the output step. A zero numerator skips the gcd
// and the divisions, and a zero denominator goes straight to the error output.
// One word is in work at a time and the next is taken the cycle after the
// result is written; a result still waiting in the output register holds the
// sequencer at its output step. Reset (aresetn low, synchronous) returns the
// sequencer to idle and empties the output register.
module fraction_reducer
    import fracred_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // numer_in [31:0], denom_in [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // numer_out [31:0], denom_out [62:32], zero [63]
    output logic        m_tuser    // status [0]
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

    seq_out_t ctl;
    flags_t   flags;

    // Working registers
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          nneg_reg, nneg_next;
    logic          dneg_reg, dneg_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [63:0]   m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    // Datapath intermediates
    logic [W-1:0] n_raw, d_raw, n_mag, d_mag;
    logic [W:0]   diff;
    logic [W:0]   rem_sh, trial;
    logic         neg;
    logic [W-1:0] nout, rd_sat;

    fracred_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctl     (ctl)
    );

    // Input magnitudes and signs
    always_comb begin
        n_raw = W'(s_tdata[31:0]);
        d_raw = W'(s_tdata[63:32]);
        n_mag = n_raw[W-1] ? (~n_raw + 1'b1) : n_raw;
        d_mag = d_raw[W-1] ? (~d_raw + 1'b1) : d_raw;
    end

    // Subtractor, divider step and result formatting
    always_comb begin
        diff   = {1'b0, b_reg} - {1'b0, a_reg};
        rem_sh = {r_reg, q_reg[W-1]};
        trial  = rem_sh - {1'b0, a_reg};
        neg    = (nneg_reg ^ dneg_reg) && (n_reg != '0);
        if (neg) begin
            nout = ~n_reg + 1'b1;
        end else begin
            nout = n_reg[W-1] ? MAXPOS : n_reg;
        end
        rd_sat = q_reg[W-1] ? MAXPOS : q_reg;
    end

    // Flags for the sequencer
    always_comb begin
        flags.in_valid = s_tvalid;
        flags.out_busy = m_tvalid_reg && !m_tready;
        flags.a_zero   = (a_reg == '0);
        flags.b_zero   = (b_reg == '0);
        flags.a_odd    = a_reg[0];
        flags.b_odd    = b_reg[0];
        flags.div_done = (cnt_reg == CW'(W));
    end

    // Next values per micro-operation
    always_comb begin
        a_next        = a_reg;
        b_next        = b_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        cnt_next      = cnt_reg;
        nneg_next     = nneg_reg;
        dneg_next     = dneg_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (ctl.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                a_next    = n_mag;
                n_next    = n_mag;
                b_next    = d_mag;
                d_next    = d_mag;
                nneg_next = n_raw[W-1];
                dneg_next = d_raw[W-1];
            end
            OP_HALVE_BOTH: begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                n_next = n_reg >> 1;
                d_next = d_reg >> 1;
            end
            OP_HALVE_A: begin
                a_next = a_reg >> 1;
            end
            OP_HALVE_B: begin
                b_next = b_reg >> 1;
            end
            OP_SUB: begin
                // Keep the smaller odd value in a, the difference in b
                if (diff[W]) begin
                    a_next = b_reg;
                    b_next = a_reg - b_reg;
                end else begin
                    b_next = diff[W-1:0];
                end
            end
            OP_DIV_INIT_N: begin
                q_next   = n_reg;
                r_next   = '0;
                cnt_next = '0;
            end
            OP_DIV_INIT_D: begin
                n_next   = q_reg;
                q_next   = d_reg;
                r_next   = '0;
                cnt_next = '0;
            end
            OP_DIV_STEP: begin
                // One quotient bit per cycle, restoring form
                if (!trial[W]) begin
                    r_next = trial[W-1:0];
                    q_next = {q_reg[W-2:0], 1'b1};
                end else begin
                    r_next = rem_sh[W-1:0];
                    q_next = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_ZERO_NUM: begin
                n_next = '0;
                q_next = W'(1);
            end
            OP_EMIT: begin
                m_tdata_next  = {1'b0, 31'(rd_sat), 32'(nout)};
                m_tuser_next  = 1'b0;
                m_tvalid_next = 1'b1;
            end
            OP_EMIT_ERR: begin
                m_tdata_next  = '0;
                m_tuser_next  = 1'b1;
                m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        nneg_reg    <= nneg_next;
        dneg_reg    <= dneg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = ctl.idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: src/fracred_checker.sv
// ============================================================================
// fracred_checker: port-level checks for the fraction reducer
// Watches the stream ports for output stability, error word form,
// one-word-at-a-time intake and reset behavior.
// ============================================================================
module fracred_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An error result carries zero numerator and denominator
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("error result with nonzero data");

    // A taken word keeps the input closed in the following cycle
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind fraction_reducer fracred_checker u_fracred_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
